>>> src/point_ema_with_jump_rejection_core_macros.svh
// Assertion macros for the port-level checker of the point smoother.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef POINT_EMA_WITH_JUMP_REJECTION_CORE_MACROS_SVH
`define POINT_EMA_WITH_JUMP_REJECTION_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PEJ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PEJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pej_pkg.sv
// Package for the 3D point smoother: payload structs, status codes,
// register indexes, reset values and datapath widths. No dependencies.
`timescale 1ns / 1ps

package pej_pkg;

	// Datapath widths
	localparam int COORD_W    = 24;
	localparam int WEIGHT_W   = 17;
	localparam int LIMIT_W    = 23;
	localparam int COUNT_W    = 8;
	localparam int LIM2_W     = 2 * LIMIT_W;
	localparam int DIST_W     = 50;
	localparam int CFG_DATA_W = 23;
	localparam int CFG_IDX_W  = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REACQUIRE_COUNT  = 2'd2;

	// Register reset values
	localparam logic [WEIGHT_W-1:0] SMOOTHING_WEIGHT_RST = 17'd19661;
	localparam logic [LIMIT_W-1:0]  JUMP_LIMIT_RST       = 23'd39322;
	localparam logic [COUNT_W-1:0]  REACQUIRE_COUNT_RST  = 8'd3;

	// Arithmetic constants
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = 8'd255;
	localparam int                  FRAC_BITS  = 16;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		STATUS_SEEDED     = 2'd0,
		STATUS_SMOOTHED   = 2'd1,
		STATUS_HELD       = 2'd2,
		STATUS_REACQUIRED = 2'd3
	} status_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} pej_in_t;

	typedef struct packed {
		coord_t  filtered_x;
		coord_t  filtered_y;
		coord_t  filtered_z;
		status_t status;
	} pej_out_t;

endpackage

>>> src/pej_dist_sq.sv
// Squared Euclidean distance between two Q8.16 points, exact.
// Depends on pej_pkg.
`timescale 1ns / 1ps

module pej_dist_sq (
	input  pej_pkg::point_t              a,
	input  pej_pkg::point_t              b,
	output logic [pej_pkg::DIST_W-1:0]   dist_sq
);
	import pej_pkg::*;

	logic signed [COORD_W:0]     dx, dy, dz;
	logic signed [2*COORD_W+1:0] sx, sy, sz;

	// Per-axis differences, one extra bit so they never wrap
	assign dx = {a.x[COORD_W-1], a.x} - {b.x[COORD_W-1], b.x};
	assign dy = {a.y[COORD_W-1], a.y} - {b.y[COORD_W-1], b.y};
	assign dz = {a.z[COORD_W-1], a.z} - {b.z[COORD_W-1], b.z};

	// Squares are non-negative and below 2^49
	assign sx = dx * dx;
	assign sy = dy * dy;
	assign sz = dz * dz;

	assign dist_sq = DIST_W'($unsigned(sx)) + DIST_W'($unsigned(sy))
		+ DIST_W'($unsigned(sz));

endmodule

>>> src/pej_blend.sv
// One axis of the smoothing update: f + round(w * (p - f)) with w in Q1.16,
// rounded half up. Depends on pej_pkg.
`timescale 1ns / 1ps

module pej_blend (
	input  pej_pkg::coord_t                 point,
	input  pej_pkg::coord_t                 filt,
	input  logic [pej_pkg::WEIGHT_W-1:0]    weight,
	output pej_pkg::coord_t                 blended
);
	import pej_pkg::*;

	localparam int PROD_W = COORD_W + 1 + WEIGHT_W + 1;
	localparam int STEP_W = PROD_W - FRAC_BITS;

	logic signed [COORD_W:0]   diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [STEP_W-1:0]  step;
	logic signed [STEP_W-1:0]  sum;

	assign diff = {point[COORD_W-1], point} - {filt[COORD_W-1], filt};
	assign prod = diff * $signed({1'b0, weight});

	// Add one half LSB, then floor by dropping the fraction bits
	assign rnd  = prod + $signed(PROD_W'(1) <<< (FRAC_BITS - 1));
	assign step = $signed(rnd[PROD_W-1:FRAC_BITS]);

	// The result lies between filt and point, so it fits back into a coordinate
	assign sum     = $signed({{(STEP_W-COORD_W){filt[COORD_W-1]}}, filt}) + step;
	assign blended = sum[COORD_W-1:0];

endmodule

>>> src/point_ema_with_jump_rejection_core.sv
// Point smoother with outlier rejection.
// Input channel (in_valid / in_stall / in_data) takes one 3D point per transaction,
// coordinates Q8.16 signed. Output channel (out_valid / out_stall / out_data) gives
// exactly one result per input point: the filtered point and a status code
// (seeded, smoothed, outlier held, reacquired).
// Throughput: one point per clock while the output is not stalled. A point accepted
// is registered in the input stage, evaluated against the filter state and then
// registered with its status into the output register, which presents it on out_data.
// The update of one point feeds the next one directly through the state registers,
// and the evaluation path is one multiplier per term, an add and a compare.
// A stalled output holds its result; the input stage keeps taking points while the
// output register is free, and in_stall rises only when both stages are full and
// the receiver stalls. in_stall never rises while out_valid is low.
// Reset clears both stage valid flags and the primed, outlier and count state (the first
// point seeds the filter) and loads defaults weight 19661, jump limit 39322, reacquire count 3.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge.
// Depends on pej_pkg, pej_dist_sq, pej_blend.
`timescale 1ns / 1ps

module point_ema_with_jump_rejection_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pej_pkg::pej_in_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pej_pkg::pej_out_t                out_data,
	input  logic                             cfg_we,
	input  logic [pej_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pej_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pej_pkg::*;

	// Configuration registers
	logic [WEIGHT_W-1:0] weight_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  reacq_q;

	// Pipeline registers
	logic     valid_s1;
	pej_in_t  data_s1;
	logic     out_valid_q;
	pej_out_t out_q;

	// Filter state
	logic               primed_q;
	logic               has_outlier_q;
	logic [COUNT_W-1:0] count_q;
	point_t             filt_q;
	point_t             last_q;

	// Next-state values
	logic               primed_n;
	logic               has_outlier_n;
	logic [COUNT_W-1:0] count_n;
	logic [COUNT_W-1:0] run_count;
	point_t             filt_n;
	point_t             last_n;
	status_t            status_n;

	point_t              point;
	point_t              blended;
	logic [DIST_W-1:0]   dist_filt;
	logic [DIST_W-1:0]   dist_last;
	logic [LIM2_W-1:0]   lim2;
	logic [WEIGHT_W-1:0] weight_sat;
	logic                is_outlier;
	logic                near_last;
	logic                advance;
	logic                fire;
	logic                load_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= SMOOTHING_WEIGHT_RST;
			limit_q  <= JUMP_LIMIT_RST;
			reacq_q  <= REACQUIRE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMOOTHING_WEIGHT: weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_JUMP_LIMIT:       limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_REACQUIRE_COUNT:  reacq_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: output register frees when empty or taken this cycle
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign load_s1   = !valid_s1 || advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			data_s1 <= in_data;
		end
	end

	assign point.x = data_s1.point_x;
	assign point.y = data_s1.point_y;
	assign point.z = data_s1.point_z;

	// Distance terms, limit squared and saturated weight
	pej_dist_sq u_dist_filt (.a(point), .b(filt_q), .dist_sq(dist_filt));
	pej_dist_sq u_dist_last (.a(point), .b(last_q), .dist_sq(dist_last));

	assign lim2       = limit_q * limit_q;
	assign is_outlier = dist_filt > DIST_W'(lim2);
	assign near_last  = dist_last <= DIST_W'(lim2);
	assign weight_sat = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;

	// Smoothing update per axis
	pej_blend u_blend_x (.point(point.x), .filt(filt_q.x), .weight(weight_sat),
		.blended(blended.x));
	pej_blend u_blend_y (.point(point.y), .filt(filt_q.y), .weight(weight_sat),
		.blended(blended.y));
	pej_blend u_blend_z (.point(point.z), .filt(filt_q.z), .weight(weight_sat),
		.blended(blended.z));

	// Seed / smooth / hold / reacquire decision
	always_comb begin
		primed_n      = 1'b1;
		has_outlier_n = 1'b0;
		count_n       = '0;
		filt_n        = filt_q;
		last_n        = last_q;
		status_n      = STATUS_SMOOTHED;
		run_count     = COUNT_W'(1);
		if (!primed_q) begin
			filt_n   = point;
			status_n = STATUS_SEEDED;
		end else if (is_outlier) begin
			if (has_outlier_q && near_last) begin
				run_count = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
			end
			last_n = point;
			if (run_count >= reacq_q) begin
				filt_n   = point;
				status_n = STATUS_REACQUIRED;
			end else begin
				has_outlier_n = 1'b1;
				count_n       = run_count;
				status_n      = STATUS_HELD;
			end
		end else begin
			filt_n = blended;
		end
	end

	// State and output register, control part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			primed_q      <= 1'b0;
			has_outlier_q <= 1'b0;
			count_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				primed_q      <= primed_n;
				has_outlier_q <= has_outlier_n;
				count_q       <= count_n;
			end
		end
	end

	// State and output register, data part
	always_ff @(posedge clk) begin
		if (fire) begin
			filt_q           <= filt_n;
			last_q           <= last_n;
			out_q.filtered_x <= filt_n.x;
			out_q.filtered_y <= filt_n.y;
			out_q.filtered_z <= filt_n.z;
			out_q.status     <= status_n;
		end
	end

endmodule

>>> src/pej_checker.sv
// Port-level checks for the point smoother, bound to the top level.
// Depends on pej_pkg and point_ema_with_jump_rejection_core_macros.svh.
`timescale 1ns / 1ps
`include "point_ema_with_jump_rejection_core_macros.svh"

module pej_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input pej_pkg::pej_out_t  out_data
);
	import pej_pkg::*;

	// Set once the first result transaction has completed
	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			seen_q <= 1'b1;
		end
	end

	// A stalled result stays put
	`PEJ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// Input side never waits on an empty output register
	`PEJ_ASSERT_NOW(a_no_idle_stall, clk, arst_n, in_valid && !out_valid, !in_stall, "input stalled while output empty")

	// First result after reset seeds the filter
	`PEJ_ASSERT_NOW(a_first_seeded, clk, arst_n, out_valid && !seen_q, out_data.status == STATUS_SEEDED, "first result not seeded")

	// Only the first result seeds
	`PEJ_ASSERT_NOW(a_seed_once, clk, arst_n, out_valid && seen_q, out_data.status != STATUS_SEEDED, "seeded status repeated")

endmodule

bind point_ema_with_jump_rejection_core pej_checker u_pej_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
